/* rtl/ccsc_pkg.sv */
// Package for the cosine change step counter.
// Holds widths, register codes, reset values, state and command types.
// No dependencies.
package ccsc_pkg;

    localparam int SAMPLE_BITS_DEF = 14;
    localparam int COS_W           = 16;
    localparam int CNT_W           = 8;
    localparam int THR_W           = 16;
    localparam int CFG_IDX_W       = 2;
    localparam int CFG_DATA_W      = 16;
    localparam int ROOT_W          = 16;
    localparam int ROOT_FRAC       = 30;

    localparam logic [CFG_IDX_W-1:0] CFG_STEP_LOW  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_HIGH = 2'd1;

    localparam logic [THR_W-1:0] STEP_LOW_RST  = 16'd1638;
    localparam logic [THR_W-1:0] STEP_HIGH_RST = 16'd3277;

    localparam logic signed [COS_W-1:0] COS_MAX = 16'sh7fff;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_INIT,
        ST_TRY,
        ST_TEST,
        ST_FINISH
    } t_state;

    // shared multiplier schedule, issued in this order
    typedef enum logic [2:0] {
        MUL_XX,
        MUL_YY,
        MUL_ZZ,
        MUL_DX,
        MUL_DY,
        MUL_DZ,
        MUL_PROD,
        MUL_DSQ
    } t_mul_sel;

    typedef struct packed {
        logic     load;
        logic     mul_en;
        t_mul_sel mul_sel;
        logic     srch_init;
        logic     srch_try;
        logic     srch_test;
        logic     finish;
    } t_dp_cmd;

    typedef struct packed {
        logic bit_last;
    } t_dp_sts;

endpackage

/* rtl/ccsc_dp.sv */
// Datapath of the cosine change step counter: shared multiplier,
// bit-serial root search, step compare, state and config registers.
// Depends on ccsc_pkg.
module ccsc_dp
    import ccsc_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  t_dp_cmd                       i_cmd,
    output t_dp_sts                       o_sts,
    input  logic signed [SAMPLE_BITS-1:0] i_accel_x,
    input  logic signed [SAMPLE_BITS-1:0] i_accel_y,
    input  logic signed [SAMPLE_BITS-1:0] i_accel_z,
    input  logic                          i_cfg_we,
    input  logic [CFG_IDX_W-1:0]          i_cfg_idx,
    input  logic [CFG_DATA_W-1:0]         i_cfg_data,
    output logic [CNT_W-1:0]              o_step_total,
    output logic                          o_step_seen,
    output logic signed [COS_W-1:0]       o_cosine_now,
    output logic                          o_cosine_ok
);

    localparam int OPW   = 2 * SAMPLE_BITS + 1;  // multiplier operand
    localparam int PW    = 2 * OPW;              // multiplier product
    localparam int MW    = 2 * SAMPLE_BITS;      // squared magnitude
    localparam int DOT_W = 2 * SAMPLE_BITS + 1;  // signed dot product
    localparam int SQW   = 4 * SAMPLE_BITS;      // prod and dot^2
    localparam int SW    = 4 * SAMPLE_BITS + 34; // search accumulators

    // config
    logic [THR_W-1:0] r_thr_lo, r_thr_hi;

    // sample state
    logic signed [SAMPLE_BITS-1:0] r_x, r_y, r_z;
    logic signed [SAMPLE_BITS-1:0] r_lx, r_ly, r_lz;
    logic [MW-1:0]                 r_mnew, r_mold;
    logic signed [DOT_W-1:0]       r_dot;
    logic [SQW-1:0]                r_prod, r_dsq;
    logic signed [COS_W-1:0]       r_last_cos;
    logic                          r_last_ok;
    logic [CNT_W-1:0]              r_count;

    // multiplier
    logic signed [OPW-1:0] mul_a, mul_b;
    logic signed [PW-1:0]  r_mul;
    logic                  r_mul_vld;
    t_mul_sel              r_mul_dst;
    logic signed [DOT_W-1:0] dot_abs;

    // root search
    logic [SW-1:0]     r_s, r_q, r_pk2, r_cand, d_ref, q_acc;
    logic [ROOT_W-1:0] r_c, r_bit;
    logic              fit;

    // finish
    logic                    ok;
    logic [ROOT_W:0]         c_ext, c_neg;
    logic signed [COS_W-1:0] cos_val;
    logic signed [COS_W:0]   diff;
    logic [COS_W:0]          diff_abs;
    logic [THR_W-1:0]        delta;
    logic                    step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr_lo <= STEP_LOW_RST;
            r_thr_hi <= STEP_HIGH_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_STEP_LOW:  r_thr_lo <= i_cfg_data[THR_W-1:0];
                CFG_STEP_HIGH: r_thr_hi <= i_cfg_data[THR_W-1:0];
                default: ;
            endcase
        end
    end

    assign dot_abs = r_dot[DOT_W-1] ? -r_dot : r_dot;

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (i_cmd.mul_sel)
            MUL_XX:   begin mul_a = OPW'(r_x);  mul_b = OPW'(r_x); end
            MUL_YY:   begin mul_a = OPW'(r_y);  mul_b = OPW'(r_y); end
            MUL_ZZ:   begin mul_a = OPW'(r_z);  mul_b = OPW'(r_z); end
            MUL_DX:   begin mul_a = OPW'(r_lx); mul_b = OPW'(r_x); end
            MUL_DY:   begin mul_a = OPW'(r_ly); mul_b = OPW'(r_y); end
            MUL_DZ:   begin mul_a = OPW'(r_lz); mul_b = OPW'(r_z); end
            MUL_PROD: begin
                mul_a = signed'(OPW'(r_mold));
                mul_b = signed'(OPW'(r_mnew));
            end
            MUL_DSQ:  begin
                mul_a = signed'(OPW'(dot_abs[MW-1:0]));
                mul_b = signed'(OPW'(dot_abs[MW-1:0]));
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_mul     <= mul_a * mul_b;
        r_mul_dst <= i_cmd.mul_sel;
        if (!i_rst_n) begin
            r_mul_vld <= 1'b0;
        end else begin
            r_mul_vld <= i_cmd.mul_en;
        end
    end

    // load sample, then accumulate products from the registered multiplier output
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_x    <= i_accel_x;
            r_y    <= i_accel_y;
            r_z    <= i_accel_z;
            r_mnew <= '0;
            r_dot  <= '0;
        end else if (r_mul_vld) begin
            case (r_mul_dst) inside
                MUL_XX, MUL_YY, MUL_ZZ: r_mnew <= r_mnew + r_mul[MW-1:0];
                MUL_DX, MUL_DY, MUL_DZ: r_dot  <= r_dot + r_mul[DOT_W-1:0];
                MUL_PROD:               r_prod <= r_mul[SQW-1:0];
                default:                r_dsq  <= r_mul[SQW-1:0];
            endcase
        end
    end

    // largest c with c^2 * prod <= dot^2 * 2^30, one bit per try/test pair.
    // S = c^2*prod, Q = c*prod*2^(k+1), pk2 = prod*2^(2k)
    assign d_ref = SW'({r_dsq, {ROOT_FRAC{1'b0}}});
    assign fit   = (r_cand <= d_ref);
    assign q_acc = fit ? r_q + (r_pk2 << 1) : r_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bit <= '0;
        end else if (i_cmd.srch_init) begin
            r_bit <= {1'b1, {(ROOT_W-1){1'b0}}};
        end else if (i_cmd.srch_test) begin
            r_bit <= r_bit >> 1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.srch_init) begin
            r_s   <= '0;
            r_q   <= '0;
            r_c   <= '0;
            r_pk2 <= SW'(r_prod) << (2 * (ROOT_W - 1));
        end else if (i_cmd.srch_try) begin
            r_cand <= r_s + r_q + r_pk2;
        end else if (i_cmd.srch_test) begin
            if (fit) begin
                r_s <= r_cand;
                r_c <= r_c | r_bit;
            end
            r_q   <= q_acc >> 1;
            r_pk2 <= r_pk2 >> 2;
        end
    end

    assign o_sts.bit_last = r_bit[0];

    // cosine, band compare
    assign ok    = (r_mold != '0) && (r_mnew != '0);
    assign c_ext = {1'b0, r_c};
    assign c_neg = -c_ext;

    always_comb begin
        if (!ok) begin
            cos_val = '0;
        end else if (r_dot[DOT_W-1]) begin
            cos_val = signed'(c_neg[COS_W-1:0]);
        end else if (c_ext > (ROOT_W+1)'(COS_MAX)) begin
            cos_val = COS_MAX;
        end else begin
            cos_val = signed'(c_ext[COS_W-1:0]);
        end
    end

    assign diff     = {cos_val[COS_W-1], cos_val} - {r_last_cos[COS_W-1], r_last_cos};
    assign diff_abs = diff[COS_W] ? -diff : diff;
    assign delta    = diff_abs[THR_W-1:0];
    assign step     = ok && r_last_ok && (delta >= r_thr_lo) && (delta <= r_thr_hi);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lx       <= '0;
            r_ly       <= '0;
            r_lz       <= '0;
            r_mold     <= '0;
            r_last_cos <= '0;
            r_last_ok  <= 1'b0;
            r_count    <= '0;
        end else if (i_cmd.finish) begin
            r_lx       <= r_x;
            r_ly       <= r_y;
            r_lz       <= r_z;
            r_mold     <= r_mnew;
            r_last_cos <= cos_val;
            r_last_ok  <= ok;
            r_count    <= r_count + CNT_W'(step);
        end
    end

    // output beat payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            o_step_total <= r_count + CNT_W'(step);
            o_step_seen  <= step;
            o_cosine_now <= cos_val;
            o_cosine_ok  <= ok;
        end
    end

`ifndef NO_ASSERTIONS
    a_bit_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(r_bit))
        else $error("search bit mask not one-hot");
    a_bad_cos_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.finish && !ok |=> o_cosine_now == '0)
        else $error("invalid cosine not zero");
    a_step_needs_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.finish |=> (!o_step_seen || o_cosine_ok))
        else $error("step counted on invalid cosine");
`endif

endmodule

/* rtl/ccsc_ctrl.sv */
// Controller of the cosine change step counter: sequences the multiplier,
// the root search and the result, and owns both channel handshakes.
// Depends on ccsc_pkg.
module ccsc_ctrl
    import ccsc_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_stall,
    output logic    o_out_valid,
    input  logic    i_out_stall,
    output t_dp_cmd o_cmd,
    input  t_dp_sts i_sts
);

    t_state     r_state, n_state;
    logic [2:0] r_cnt, n_cnt;
    logic       r_out_valid, n_out_valid;
    logic       in_take, out_take;

    assign o_in_stall  = (r_state != ST_IDLE);
    assign in_take     = i_in_valid && !o_in_stall;
    assign out_take    = r_out_valid && !i_out_stall;
    assign o_out_valid = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state       = r_state;
        n_cnt         = r_cnt;
        n_out_valid   = out_take ? 1'b0 : r_out_valid;
        o_cmd         = '0;
        o_cmd.mul_sel = t_mul_sel'(r_cnt);
        unique case (r_state)
            ST_IDLE: begin
                if (in_take) begin
                    o_cmd.load = 1'b1;
                    n_cnt      = '0;
                    n_state    = ST_MUL;
                end
            end
            ST_MUL: begin
                o_cmd.mul_en = 1'b1;
                n_cnt        = r_cnt + 3'd1;
                if (t_mul_sel'(r_cnt) == MUL_DSQ) begin
                    n_state = ST_INIT;
                end
            end
            ST_INIT: begin
                o_cmd.srch_init = 1'b1;
                n_state         = ST_TRY;
            end
            ST_TRY: begin
                o_cmd.srch_try = 1'b1;
                n_state        = ST_TEST;
            end
            ST_TEST: begin
                o_cmd.srch_test = 1'b1;
                n_state         = i_sts.bit_last ? ST_FINISH : ST_TRY;
            end
            ST_FINISH: begin
                // hold until the output register is free or drains now
                if (!r_out_valid || !i_out_stall) begin
                    o_cmd.finish = 1'b1;
                    n_out_valid  = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

`ifndef NO_ASSERTIONS
    a_take_starts_mul: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_take |=> (r_state == ST_MUL) && (r_cnt == '0))
        else $error("accepted beat did not start the multiply sequence");
    a_valid_from_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state) == ST_FINISH)
        else $error("output valid raised outside finish");
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_FINISH) && r_out_valid && i_out_stall |=> r_state == ST_FINISH)
        else $error("result written over a pending beat");
`endif

endmodule

/* rtl/cosine_change_step_counter_unit.sv */
// Top level of the cosine change step counter.
// Instantiates ccsc_ctrl and ccsc_dp; depends on ccsc_pkg.
//
// Usage:
//  - Input channel (i_in_valid / o_in_stall): one beat is one accelerometer
//    sample x, y, z. A beat is taken when valid is high and stall is low.
//  - Output channel (o_out_valid / i_out_stall): one result beat per sample:
//    running step total, step flag, Q1.15 cosine to the previous sample and
//    its valid flag.
//  - Config port: i_cfg_we with i_cfg_idx 0 writes the low band edge,
//    1 the high band edge; other indexes are ignored. Write only when idle.
//  - Sequence after an input beat is taken: the shared multiplier forms
//    the three squares, three dot terms, magnitude product and dot
//    squared, then come a search setup step, the bit-serial root search
//    (a try and a test step for each of 16 cosine bits) and the finish
//    step, which writes the result into the output register.
//  - Input stalls while a sample is in flight, up to its finish step.
//  - The output register parts the channels: a new sample is taken while
//    the last result still waits. If the receiver stalls, the next result
//    holds in the finish step until the pending beat leaves.
//  - Reset (synchronous, active low): previous sample, cosine and count
//    cleared, cosine marked invalid, band edges back to 1638 and 3277.
module cosine_change_step_counter_unit
    import ccsc_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // input channel
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic signed [SAMPLE_BITS-1:0] i_accel_x,
    input  logic signed [SAMPLE_BITS-1:0] i_accel_y,
    input  logic signed [SAMPLE_BITS-1:0] i_accel_z,
    // config write port
    input  logic                          i_cfg_we,
    input  logic [CFG_IDX_W-1:0]          i_cfg_idx,
    input  logic [CFG_DATA_W-1:0]         i_cfg_data,
    // output channel
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [CNT_W-1:0]              o_step_total,
    output logic                          o_step_seen,
    output logic signed [COS_W-1:0]       o_cosine_now,
    output logic                          o_cosine_ok
);

    t_dp_cmd dp_cmd;
    t_dp_sts dp_sts;

    ccsc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_cmd       (dp_cmd),
        .i_sts       (dp_sts)
    );

    ccsc_dp #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (dp_cmd),
        .o_sts        (dp_sts),
        .i_accel_x    (i_accel_x),
        .i_accel_y    (i_accel_y),
        .i_accel_z    (i_accel_z),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .o_step_total (o_step_total),
        .o_step_seen  (o_step_seen),
        .o_cosine_now (o_cosine_now),
        .o_cosine_ok  (o_cosine_ok)
    );

endmodule

/* tb/cosine_change_step_counter_unit_tb.sv */
// Self-checking testbench for cosine_change_step_counter_unit.
// Depends on ccsc_pkg and the RTL top level with its submodules.
module cosine_change_step_counter_unit_tb;
    import ccsc_pkg::*;

    localparam int SB        = SAMPLE_BITS_DEF;
    localparam int AXIS_MAX  = (1 << (SB - 1)) - 1;
    localparam int AXIS_MIN  = -(1 << (SB - 1));
    localparam int LATENCY   = 42;    // input beat to result beat
    localparam int LONG_HOLD = 500;   // well past one sample time, so the block backs up

    // indexes with no register behind them; writes there must be dropped
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_2 = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_3 = 2'd3;

    typedef struct packed {
        logic signed [SB-1:0] x;
        logic signed [SB-1:0] y;
        logic signed [SB-1:0] z;
    } t_accel_sample;

    typedef struct packed {
        logic [CNT_W-1:0]        total;
        logic                    seen;
        logic signed [COS_W-1:0] cosine;
        logic                    ok;
    } t_step_report;

    // ---------------------------------------------------------------------
    // Clock, reset and DUT hookup
    // ---------------------------------------------------------------------
    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    logic                    in_valid  = 1'b0;
    logic                    in_stall;
    logic signed [SB-1:0]    ax        = '0;
    logic signed [SB-1:0]    ay        = '0;
    logic signed [SB-1:0]    az        = '0;
    logic                    cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]    cfg_idx   = CFG_STEP_LOW;
    logic [CFG_DATA_W-1:0]   cfg_data  = '0;
    logic                    out_valid;
    logic                    out_stall = 1'b0;
    logic [CNT_W-1:0]        step_total;
    logic                    step_seen;
    logic signed [COS_W-1:0] cosine_now;
    logic                    cosine_ok;

    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    cosine_change_step_counter_unit #(
        .SAMPLE_BITS (SB)
    ) u_dut (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .o_in_stall   (in_stall),
        .i_accel_x    (ax),
        .i_accel_y    (ay),
        .i_accel_z    (az),
        .i_cfg_we     (cfg_we),
        .i_cfg_idx    (cfg_idx),
        .i_cfg_data   (cfg_data),
        .o_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .o_step_total (step_total),
        .o_step_seen  (step_seen),
        .o_cosine_now (cosine_now),
        .o_cosine_ok  (cosine_ok)
    );

    // ---------------------------------------------------------------------
    // Predictor state: mirrors the block's registers after reset
    // ---------------------------------------------------------------------
    t_accel_sample  prev_sample  = '0;
    int             prev_cos     = 0;
    bit             prev_cos_ok  = 1'b0;
    logic [CNT_W-1:0] step_tally = '0;
    logic [THR_W-1:0] band_low   = STEP_LOW_RST;
    logic [THR_W-1:0] band_high  = STEP_HIGH_RST;

    t_accel_sample pending_samples[$];   // waiting to be offered as input beats
    t_step_report  expected_reports[$];  // predicted result beats, oldest first
    t_accel_sample gen_prev = '0;        // last sample queued, seeds the slow-drift stimulus

    int mismatches      = 0;
    int samples_taken   = 0;
    int results_checked = 0;
    int steps_flagged   = 0;
    int invalid_cosines = 0;
    int band_settings   = 1;
    int long_holds      = 0;

    // Exact cosine in Q1.15: largest c with c^2 * |a|^2 * |b|^2 <= dot^2 * 2^30,
    // found bit by bit from the top. Negative dot gives -c, positive saturates.
    function automatic void cosine_between(input t_accel_sample a, input t_accel_sample b,
                                           output int cosv, output bit okv);
        longint       a0, a1, a2, b0, b1, b2, dot, mag;
        logic [63:0]  m_a, m_b;
        logic [127:0] prod, dsq, lhs;
        logic [15:0]  c, t;
        a0 = $signed(a.x); a1 = $signed(a.y); a2 = $signed(a.z);
        b0 = $signed(b.x); b1 = $signed(b.y); b2 = $signed(b.z);
        dot = a0 * b0 + a1 * b1 + a2 * b2;
        m_a = a0 * a0 + a1 * a1 + a2 * a2;
        m_b = b0 * b0 + b1 * b1 + b2 * b2;
        okv  = (m_a != 0) && (m_b != 0);
        cosv = 0;
        if (!okv) begin
            return;
        end
        prod = m_a * m_b;
        mag  = (dot < 0) ? -dot : dot;
        dsq  = mag * mag;
        c    = '0;
        for (int k = 15; k >= 0; k--) begin
            t   = c | (16'd1 << k);
            lhs = t * t * prod;
            if (lhs <= (dsq << 30)) begin
                c = t;
            end
        end
        if (dot < 0) begin
            cosv = -int'(c);
        end else begin
            cosv = (int'(c) > int'(COS_MAX)) ? int'(COS_MAX) : int'(c);
        end
    endfunction

    // Advance the mirrored state by one accepted sample and return its result.
    function automatic t_step_report predict_step_report(input t_accel_sample s);
        t_step_report r;
        int           cosv, delta;
        bit           okv, hit;
        cosine_between(prev_sample, s, cosv, okv);
        hit = 1'b0;
        // an invalid cosine on either side blocks the comparison
        if (okv && prev_cos_ok) begin
            delta = cosv - prev_cos;
            if (delta < 0) begin
                delta = -delta;
            end
            hit = (delta >= int'(band_low)) && (delta <= int'(band_high));
        end
        if (hit) begin
            step_tally = step_tally + 1'b1;
        end
        prev_sample = s;
        prev_cos    = cosv;
        prev_cos_ok = okv;
        r.total  = step_tally;
        r.seen   = hit;
        r.cosine = cosv[COS_W-1:0];
        r.ok     = okv;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        mismatches++;
        if (mismatches <= 40) begin
            $display("[%0t] mismatch on %s: got %0d, expected %0d", $time, what, got, want);
        end
    endtask

    // ---------------------------------------------------------------------
    // Stimulus helpers
    // ---------------------------------------------------------------------
    function automatic logic signed [SB-1:0] clamp_axis(input int v);
        if (v > AXIS_MAX) begin
            return SB'(AXIS_MAX);
        end
        if (v < AXIS_MIN) begin
            return SB'(AXIS_MIN);
        end
        return SB'(v);
    endfunction

    function automatic t_accel_sample xyz(input int x, input int y, input int z);
        t_accel_sample s;
        s.x = clamp_axis(x);
        s.y = clamp_axis(y);
        s.z = clamp_axis(z);
        return s;
    endfunction

    function automatic int pick_extreme();
        case ($urandom_range(0, 4))
            0: return AXIS_MIN;
            1: return AXIS_MAX;
            2: return 0;
            3: return -1;
            default: return 1;
        endcase
    endfunction

    // Half slow drift from the last sample so the cosine change lands near the
    // step band; the rest is full-range noise, tiny and zero vectors, extremes and
    // (anti)parallel repeats.
    function automatic t_accel_sample make_sample();
        int kind, spread;
        kind = $urandom_range(0, 99);
        if (kind < 50) begin
            case ($urandom_range(0, 2))
                0: spread = 60;
                1: spread = 500;
                default: spread = 2000;
            endcase
            return xyz(int'($signed(gen_prev.x)) + int'($urandom_range(0, 2 * spread)) - spread,
                       int'($signed(gen_prev.y)) + int'($urandom_range(0, 2 * spread)) - spread,
                       int'($signed(gen_prev.z)) + int'($urandom_range(0, 2 * spread)) - spread);
        end else if (kind < 70) begin
            return {SB'($urandom), SB'($urandom), SB'($urandom)};
        end else if (kind < 80) begin
            return xyz(int'($urandom_range(0, 6)) - 3, int'($urandom_range(0, 6)) - 3,
                       int'($urandom_range(0, 6)) - 3);
        end else if (kind < 85) begin
            return '0;
        end else if (kind < 92) begin
            return xyz(pick_extreme(), pick_extreme(), pick_extreme());
        end else if (kind < 96) begin
            return gen_prev;
        end
        return xyz(-int'($signed(gen_prev.x)), -int'($signed(gen_prev.y)),
                   -int'($signed(gen_prev.z)));
    endfunction

    function automatic void queue_sample(input t_accel_sample s);
        pending_samples.push_back(s);
        gen_prev = s;
    endfunction

    // Register writes go out on rising edges, only while nothing is in flight.
    task automatic write_band_reg(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] v);
        @(posedge clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= v;
        if (idx == CFG_STEP_LOW) begin
            band_low = v;
        end else if (idx == CFG_STEP_HIGH) begin
            band_high = v;
        end
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic set_band(input int lo, input int hi);
        write_band_reg(CFG_STEP_LOW, CFG_DATA_W'(lo));
        write_band_reg(CFG_STEP_HIGH, CFG_DATA_W'(hi));
        band_settings++;
    endtask

    // Sender pause: hold everything back until the last predicted beat is in.
    task automatic wait_drained();
        while (pending_samples.size() != 0 || expected_reports.size() != 0) begin
            @(posedge clk);
        end
        @(negedge clk);
    endtask

    // ---------------------------------------------------------------------
    // Driver: bursts of beats from pending_samples with random gaps between.
    // A beat stays put while stalled; valid is assigned once per edge.
    // ---------------------------------------------------------------------
    int burst_left = 1;
    int gap_left   = 0;

    always @(posedge clk) begin
        bit took;
        took = in_valid && !in_stall;
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (took) begin
                expected_reports.push_back(predict_step_report(pending_samples.pop_front()));
                samples_taken++;
            end
            if (!in_valid || took) begin
                if (gap_left > 0) begin
                    gap_left--;
                    in_valid <= 1'b0;
                end else if (pending_samples.size() > 0) begin
                    in_valid <= 1'b1;
                    ax       <= pending_samples[0].x;
                    ay       <= pending_samples[0].y;
                    az       <= pending_samples[0].z;
                    if (burst_left > 1) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(1, 40);
                        gap_left   = ($urandom_range(0, 9) < 4) ? 0 : $urandom_range(1, 70);
                    end
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // ---------------------------------------------------------------------
    // Receiver: random stalls, density redrawn among 0, 20, 50 and 85 percent;
    // twice, while the sender is offering, it starts a long hold-off, which
    // fills the output register and the search and backs up the input.
    // ---------------------------------------------------------------------
    int rx_cycle  = 0;
    int hold_left = 0;
    int stall_pct = 0;

    always @(posedge clk) begin
        rx_cycle++;
        if (!rst_n) begin
            out_stall <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            out_stall <= 1'b1;
        end else if (in_valid && ((rx_cycle >= 2500 && long_holds == 0) ||
                                  (rx_cycle >= 20000 && long_holds == 1))) begin
            long_holds++;
            hold_left = LONG_HOLD;
            out_stall <= 1'b1;
        end else begin
            if (rx_cycle % 64 == 0) begin
                case ($urandom_range(0, 4))
                    0, 1: stall_pct = 0;
                    2: stall_pct = 20;
                    3: stall_pct = 50;
                    default: stall_pct = 85;
                endcase
            end
            out_stall <= ($urandom_range(0, 99) < stall_pct);
        end
    end

    // ---------------------------------------------------------------------
    // Monitor: every result beat against the oldest prediction
    // ---------------------------------------------------------------------
    always @(posedge clk) begin
        t_step_report want;
        if (rst_n && out_valid && !out_stall) begin
            if (expected_reports.size() == 0) begin
                report_mismatch("result beat with nothing pending, cosine", int'(cosine_now), 0);
            end else begin
                want = expected_reports.pop_front();
                results_checked++;
                if (want.seen) begin
                    steps_flagged++;
                end
                if (!want.ok) begin
                    invalid_cosines++;
                end
                if (step_total !== want.total) begin
                    report_mismatch("step_total", int'(step_total), int'(want.total));
                end
                if (step_seen !== want.seen) begin
                    report_mismatch("step_seen", int'(step_seen), int'(want.seen));
                end
                if (cosine_now !== want.cosine) begin
                    report_mismatch("cosine_now", int'(cosine_now), int'(want.cosine));
                end
                if (cosine_ok !== want.ok) begin
                    report_mismatch("cosine_ok", int'(cosine_ok), int'(want.ok));
                end
            end
        end
    end

    // ---------------------------------------------------------------------
    // Test sequence
    // ---------------------------------------------------------------------
    initial begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed part, reset band (1638..3277) left as it is.
        queue_sample(xyz(8000, 0, 0));          // first after reset: previous is zero
        queue_sample(xyz(8000, 0, 0));          // parallel, saturates; previous invalid
        queue_sample(xyz(8000, 2970, 0));       // change of about 2047: a step
        queue_sample(xyz(8000, 2970, 0));       // back to full scale: another step
        queue_sample(xyz(-8000, -2970, 0));     // antiparallel: most negative cosine
        queue_sample(xyz(0, 0, 0));             // zero magnitude
        queue_sample(xyz(AXIS_MAX, AXIS_MAX, AXIS_MAX)); // previous was zero
        queue_sample(xyz(AXIS_MAX, AXIS_MAX, AXIS_MAX)); // valid, but prior invalid
        queue_sample(xyz(AXIS_MIN, AXIS_MIN, AXIS_MIN));
        queue_sample(xyz(AXIS_MAX, AXIS_MIN, 0));
        queue_sample(xyz(AXIS_MIN, AXIS_MAX, AXIS_MIN));
        queue_sample(xyz(1, 0, 0));
        queue_sample(xyz(0, 1, 0));             // orthogonal
        queue_sample(xyz(0, 0, -1));
        queue_sample(xyz(-1, -1, -1));
        queue_sample(xyz(AXIS_MAX, 0, 0));
        queue_sample(xyz(AXIS_MIN, 0, 0));      // exactly opposite, unequal lengths
        queue_sample(xyz(0, AXIS_MIN, 0));
        queue_sample(xyz(1, 1, 0));
        queue_sample(xyz(1, 1, 1));
        queue_sample(xyz(AXIS_MAX, AXIS_MAX, AXIS_MIN));
        queue_sample(xyz(AXIS_MAX, AXIS_MAX, AXIS_MIN));
        wait_drained();

        // Random part: one batch per band setting, block idle between batches.
        for (int phase = 0; phase < 8; phase++) begin
            case (phase)
                0: set_band(int'(STEP_LOW_RST), int'(STEP_HIGH_RST));
                1: set_band(0, 65535);            // every valid pair counts
                2: set_band(0, 0);                // only an unchanged cosine counts
                3: set_band(65535, 65535);
                4: set_band(5000, 100);           // inverted band, never a step
                5: begin
                    set_band(300, 8000);
                    // no register at these indexes; the band must stay as it is
                    write_band_reg(CFG_SPARE_2, 16'h0000);
                    write_band_reg(CFG_SPARE_3, 16'hffff);
                end
                6: begin
                    int lo;
                    lo = $urandom_range(0, 4000);
                    set_band(lo, lo + int'($urandom_range(0, 6000)));
                end
                default: set_band(1000, 1000);
            endcase
            @(negedge clk);
            repeat (128) queue_sample(make_sample());
            wait_drained();
        end

        // let any stray beat show up before judging
        repeat (LATENCY + 20) @(posedge clk);
        $display("Covered %0d samples under %0d band settings: %0d results checked,",
                 samples_taken, band_settings, results_checked);
        $display("%0d steps, %0d invalid cosines, %0d receiver long hold-offs, %0d mismatches.",
                 steps_flagged, invalid_cosines, long_holds, mismatches);
        if (mismatches == 0 && expected_reports.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    // Watchdog, several times the slowest legal run.
    initial begin
        #2_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule

/* files.f */
rtl/ccsc_pkg.sv
rtl/ccsc_dp.sv
rtl/ccsc_ctrl.sv
rtl/cosine_change_step_counter_unit.sv
tb/cosine_change_step_counter_unit_tb.sv
